>>> hdl/svna_pkg.sv
// Package with the constants, types and state encodings shared by the normal accumulator.
`timescale 1ns / 1ps
`default_nettype none
package svna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int POS_WIDTH    = 16;
  localparam int SUM_WIDTH    = 24;
  localparam int EDGE_W       = POS_WIDTH + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int VEC_W        = PROD_W + 1;
  localparam int NRM_W        = 16;
  localparam int POS_ROW_W    = 3 * POS_WIDTH;
  localparam int SUM_ROW_W    = 3 * SUM_WIDTH;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FACE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_ZERO  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    T_CLEAR,
    T_IDLE,
    T_RDA,
    T_RDB,
    T_RDC,
    T_EDGE,
    T_CROSS,
    T_CHECK,
    T_FNORM,
    T_ARD,
    T_AWR,
    T_QRD,
    T_QCHK,
    T_QNORM
  } top_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DIVI,
    N_DIVS,
    N_STORE,
    N_DONE
  } norm_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } norm_stat_t;

endpackage
`default_nettype wire

>>> hdl/svna_norm.sv
// Iterative normalizer that scales a signed three-component vector to a Q1.14 unit vector.
`timescale 1ns / 1ps
`default_nettype none
module svna_norm (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic signed [svna_pkg::VEC_W-1:0]      vec_x_i,
  input  wire logic signed [svna_pkg::VEC_W-1:0]      vec_y_i,
  input  wire logic signed [svna_pkg::VEC_W-1:0]      vec_z_i,
  output svna_pkg::norm_stat_t                        stat_o,
  output logic signed [svna_pkg::NRM_W-1:0]           nrm_x_o,
  output logic signed [svna_pkg::NRM_W-1:0]           nrm_y_o,
  output logic signed [svna_pkg::NRM_W-1:0]           nrm_z_o
);

  localparam int MW    = svna_pkg::VEC_W;
  localparam int RW    = 15;
  localparam int SW    = 2 * RW + 2;
  localparam int XW    = SW + 28;
  localparam int LW    = XW / 2;
  localparam int NUMW  = RW + 28 + 1;
  localparam int QW    = 16;
  localparam int REMW  = LW + 1;
  localparam int NW    = svna_pkg::NRM_W;

  svna_pkg::norm_state_e state_q, state_d;

  logic [MW-1:0]           mag_q [3];
  logic [2:0]              neg_q;
  logic [SW-1:0]           s_q;
  logic [XW-1:0]           x_q;
  logic [XW-1:0]           r_q;
  logic [XW-1:0]           bit_q;
  logic [LW-1:0]           len_q;
  logic [REMW-1:0]         rem_q;
  logic [QW-1:0]           lo_q;
  logic [QW-1:0]           q_q;
  logic [4:0]              cnt_q;
  logic [1:0]              comp_q;
  logic signed [NW-1:0]    n_q [3];

  logic                    big;
  logic [2*RW-1:0]         sq;
  logic [XW-1:0]           trial;
  logic [NUMW-1:0]         num;
  logic [REMW-1:0]         rem2;
  logic                    qbit;
  logic [QW-1:0]           qc;
  logic [MW-1:0]           in_mag [3];
  logic [2:0]              in_neg;
  logic signed [MW-1:0]    in_vec [3];

  always_comb begin
    in_vec[0] = vec_x_i;
    in_vec[1] = vec_y_i;
    in_vec[2] = vec_z_i;
    for (int i = 0; i < 3; i++) begin
      in_neg[i] = in_vec[i][MW-1];
      in_mag[i] = in_neg[i] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
    end
  end

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      big = big | (|mag_q[i][MW-1:RW]);
    end
    sq    = mag_q[cnt_q[1:0]][RW-1:0] * mag_q[cnt_q[1:0]][RW-1:0];
    trial = r_q + bit_q;
    num   = {1'b0, mag_q[comp_q][RW-1:0], 28'd0} + NUMW'(len_q >> 1);
    rem2  = {rem_q[REMW-2:0], lo_q[QW-1]};
    qbit  = (rem2 >= {1'b0, len_q});
    qc    = (q_q > QW'(16384)) ? QW'(16384) : q_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      svna_pkg::N_IDLE:  if (start_i) state_d = svna_pkg::N_SHIFT;
      svna_pkg::N_SHIFT: if (!big) state_d = svna_pkg::N_SQ;
      svna_pkg::N_SQ:    if (cnt_q == 5'd2) state_d = svna_pkg::N_SQRT;
      svna_pkg::N_SQRT:  if (cnt_q == 5'(LW - 1)) state_d = svna_pkg::N_DIVI;
      svna_pkg::N_DIVI:  state_d = svna_pkg::N_DIVS;
      svna_pkg::N_DIVS:  if (cnt_q == 5'(QW - 1)) state_d = svna_pkg::N_STORE;
      svna_pkg::N_STORE: state_d = (comp_q == 2'd2) ? svna_pkg::N_DONE : svna_pkg::N_DIVI;
      svna_pkg::N_DONE:  state_d = svna_pkg::N_IDLE;
      default:           state_d = svna_pkg::N_IDLE;
    endcase
  end

  always_comb begin
    stat_o.busy = (state_q != svna_pkg::N_IDLE);
    stat_o.done = (state_q == svna_pkg::N_DONE);
    nrm_x_o     = n_q[0];
    nrm_y_o     = n_q[1];
    nrm_z_o     = n_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svna_pkg::N_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        svna_pkg::N_SHIFT: cnt_q <= '0;
        svna_pkg::N_SQ:    cnt_q <= (cnt_q == 5'd2) ? 5'd0 : cnt_q + 5'd1;
        svna_pkg::N_SQRT: begin
          cnt_q  <= (cnt_q == 5'(LW - 1)) ? 5'd0 : cnt_q + 5'd1;
          comp_q <= '0;
        end
        svna_pkg::N_DIVI:  cnt_q <= '0;
        svna_pkg::N_DIVS:  cnt_q <= cnt_q + 5'd1;
        svna_pkg::N_STORE: comp_q <= comp_q + 2'd1;
        default: begin
          cnt_q  <= '0;
          comp_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      svna_pkg::N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= in_mag[i];
          end
          neg_q <= in_neg;
        end
        s_q <= '0;
      end
      svna_pkg::N_SHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
        end
        s_q <= '0;
      end
      svna_pkg::N_SQ: begin
        s_q <= s_q + SW'(sq);
        if (cnt_q == 5'd2) begin
          x_q   <= {s_q + SW'(sq), 28'd0};
          r_q   <= '0;
          bit_q <= XW'(1) << (XW - 2);
        end
      end
      svna_pkg::N_SQRT: begin
        if (x_q >= trial) begin
          x_q <= x_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (cnt_q == 5'(LW - 1)) begin
          len_q <= (x_q >= trial) ? LW'((r_q >> 1) + bit_q) : LW'(r_q >> 1);
        end
      end
      svna_pkg::N_DIVI: begin
        rem_q <= REMW'(num[NUMW-1:QW]);
        lo_q  <= num[QW-1:0];
        q_q   <= '0;
      end
      svna_pkg::N_DIVS: begin
        rem_q <= qbit ? (rem2 - {1'b0, len_q}) : rem2;
        lo_q  <= lo_q << 1;
        q_q   <= {q_q[QW-2:0], qbit};
      end
      svna_pkg::N_STORE: begin
        n_q[comp_q] <= neg_q[comp_q] ? NW'(-qc) : NW'(qc);
      end
      default: begin
        s_q <= s_q;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/smooth_vertex_normal_accumulator_top.sv
// Top level: position and sum memories, request sequencer, cross product and accumulation.
// After reset a clearing pass zeroes all 1024 entries of the sum memory; busy stays high meanwhile.
// A load or unknown request gets its result in the cycle after the transfer; a zero-sum query
// and a degenerate face skip the normalizer, while other queries and faces wait on it: it shifts
// a large vector right, then takes the square root and divides at one bit a cycle.
// One request is in flight at a time, busy holds off the next; the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module smooth_vertex_normal_accumulator_top (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [1:0]                             req_type_i,
  input  wire logic [svna_pkg::IDX_W-1:0]             vertex_index_i,
  input  wire logic signed [svna_pkg::POS_WIDTH-1:0]  pos_x_i,
  input  wire logic signed [svna_pkg::POS_WIDTH-1:0]  pos_y_i,
  input  wire logic signed [svna_pkg::POS_WIDTH-1:0]  pos_z_i,
  input  wire logic [svna_pkg::IDX_W-1:0]             corner_a_i,
  input  wire logic [svna_pkg::IDX_W-1:0]             corner_b_i,
  input  wire logic [svna_pkg::IDX_W-1:0]             corner_c_i,
  output logic                                        result_valid_o,
  output logic signed [svna_pkg::NRM_W-1:0]           normal_x_o,
  output logic signed [svna_pkg::NRM_W-1:0]           normal_y_o,
  output logic signed [svna_pkg::NRM_W-1:0]           normal_z_o,
  output logic [1:0]                                  status_o
);

  localparam int IW  = svna_pkg::IDX_W;
  localparam int PW  = svna_pkg::POS_WIDTH;
  localparam int SW  = svna_pkg::SUM_WIDTH;
  localparam int EW  = svna_pkg::EDGE_W;
  localparam int MW  = svna_pkg::PROD_W;
  localparam int VW  = svna_pkg::VEC_W;
  localparam int NW  = svna_pkg::NRM_W;
  localparam int PRW = svna_pkg::POS_ROW_W;
  localparam int SRW = svna_pkg::SUM_ROW_W;
  localparam logic signed [SW:0] SUM_HI = (SW+1)'((2 ** (SW - 1)) - 1);
  localparam logic signed [SW:0] SUM_LO = -SUM_HI - (SW+1)'(1);

  svna_pkg::top_state_e state_q, state_d;

  logic [PRW-1:0]          pos_mem [svna_pkg::MAX_VERTICES];
  logic [SRW-1:0]          sum_mem [svna_pkg::MAX_VERTICES];
  logic [PRW-1:0]          pos_rd_q;
  logic [SRW-1:0]          sum_rd_q;

  logic                    accept;
  logic                    pos_re;
  logic [IW-1:0]           pos_raddr;
  logic                    sum_we, sum_re;
  logic [IW-1:0]           sum_waddr, sum_raddr;
  logic [SRW-1:0]          sum_wdata;

  logic [IW-1:0]           clr_q;
  logic [IW-1:0]           ca_q, cb_q, cc_q, vi_q;
  logic [PRW-1:0]          pa_q, pb_q;
  logic signed [EW-1:0]    e1_q [3];
  logic signed [EW-1:0]    e2_q [3];
  logic [2:0]              step_q;
  logic signed [MW-1:0]    prod_q, hold_q;
  logic signed [VW-1:0]    cr_q [3];
  logic [1:0]              j_q;
  logic                    sat_q;

  logic                    res_valid_q;
  logic signed [NW-1:0]    res_x_q, res_y_q, res_z_q;
  logic [1:0]              res_st_q;

  logic signed [EW-1:0]    op_a, op_b;
  logic [2:0]              prev;
  logic                    cr_zero, sum_zero;
  logic [IW-1:0]           cur_idx;
  logic signed [NW-1:0]    nv [3];
  logic signed [SW:0]      t [3];
  logic signed [SW-1:0]    r [3];
  logic                    sat_now;
  logic                    norm_start;
  logic                    res_fire;
  logic signed [VW-1:0]    nin [3];
  svna_pkg::norm_stat_t    nstat;
  logic signed [NW-1:0]    nx, ny, nz;

  assign accept = start && !busy;

  always_comb begin
    case (step_q)
      3'd0: begin op_a = e1_q[1]; op_b = e2_q[2]; end
      3'd1: begin op_a = e1_q[2]; op_b = e2_q[1]; end
      3'd2: begin op_a = e1_q[2]; op_b = e2_q[0]; end
      3'd3: begin op_a = e1_q[0]; op_b = e2_q[2]; end
      3'd4: begin op_a = e1_q[0]; op_b = e2_q[1]; end
      3'd5: begin op_a = e1_q[1]; op_b = e2_q[0]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
    prev     = step_q - 3'd1;
    cr_zero  = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
    sum_zero = (sum_rd_q == '0);
    case (j_q)
      2'd0:    cur_idx = ca_q;
      2'd1:    cur_idx = cb_q;
      default: cur_idx = cc_q;
    endcase
    nv[0]   = nx;
    nv[1]   = ny;
    nv[2]   = nz;
    sat_now = 1'b0;
    for (int i = 0; i < 3; i++) begin
      t[i] = (SW+1)'(signed'(sum_rd_q[SW*i +: SW])) + (SW+1)'(nv[i]);
      if (t[i] > SUM_HI) begin
        r[i] = SW'(SUM_HI);
        sat_now = 1'b1;
      end else if (t[i] < SUM_LO) begin
        r[i] = SW'(SUM_LO);
        sat_now = 1'b1;
      end else begin
        r[i] = SW'(t[i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      nin[i] = (state_q == svna_pkg::T_QCHK) ?
               VW'(signed'(sum_rd_q[SW*i +: SW])) : cr_q[i];
    end
    norm_start = ((state_q == svna_pkg::T_CHECK) && !cr_zero) ||
                 ((state_q == svna_pkg::T_QCHK) && !sum_zero);
    res_fire   = (accept && (req_type_i != svna_pkg::REQ_FACE) &&
                  (req_type_i != svna_pkg::REQ_QUERY)) ||
                 ((state_q == svna_pkg::T_CHECK) && cr_zero) ||
                 ((state_q == svna_pkg::T_AWR) && (j_q == 2'd2)) ||
                 ((state_q == svna_pkg::T_QCHK) && sum_zero) ||
                 ((state_q == svna_pkg::T_QNORM) && nstat.done);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      svna_pkg::T_CLEAR: if (clr_q == IW'(svna_pkg::MAX_VERTICES - 1)) state_d = svna_pkg::T_IDLE;
      svna_pkg::T_IDLE: begin
        if (accept) begin
          case (req_type_i)
            svna_pkg::REQ_FACE:  state_d = svna_pkg::T_RDA;
            svna_pkg::REQ_QUERY: state_d = svna_pkg::T_QRD;
            default:             state_d = svna_pkg::T_IDLE;
          endcase
        end
      end
      svna_pkg::T_RDA:   state_d = svna_pkg::T_RDB;
      svna_pkg::T_RDB:   state_d = svna_pkg::T_RDC;
      svna_pkg::T_RDC:   state_d = svna_pkg::T_EDGE;
      svna_pkg::T_EDGE:  state_d = svna_pkg::T_CROSS;
      svna_pkg::T_CROSS: if (step_q == 3'd6) state_d = svna_pkg::T_CHECK;
      svna_pkg::T_CHECK: state_d = cr_zero ? svna_pkg::T_IDLE : svna_pkg::T_FNORM;
      svna_pkg::T_FNORM: if (nstat.done) state_d = svna_pkg::T_ARD;
      svna_pkg::T_ARD:   state_d = svna_pkg::T_AWR;
      svna_pkg::T_AWR:   state_d = (j_q == 2'd2) ? svna_pkg::T_IDLE : svna_pkg::T_ARD;
      svna_pkg::T_QRD:   state_d = svna_pkg::T_QCHK;
      svna_pkg::T_QCHK:  state_d = sum_zero ? svna_pkg::T_IDLE : svna_pkg::T_QNORM;
      svna_pkg::T_QNORM: if (nstat.done) state_d = svna_pkg::T_IDLE;
      default:           state_d = svna_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_q != svna_pkg::T_IDLE);
    pos_re    = (state_q == svna_pkg::T_RDA) || (state_q == svna_pkg::T_RDB) ||
                (state_q == svna_pkg::T_RDC);
    case (state_q)
      svna_pkg::T_RDA: pos_raddr = ca_q;
      svna_pkg::T_RDB: pos_raddr = cb_q;
      default:         pos_raddr = cc_q;
    endcase
    sum_re    = (state_q == svna_pkg::T_ARD) || (state_q == svna_pkg::T_QRD);
    sum_raddr = (state_q == svna_pkg::T_QRD) ? vi_q : cur_idx;
    sum_we    = 1'b0;
    sum_waddr = cur_idx;
    sum_wdata = '0;
    if (state_q == svna_pkg::T_CLEAR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_q;
    end else if (accept && (req_type_i == svna_pkg::REQ_LOAD)) begin
      sum_we    = 1'b1;
      sum_waddr = vertex_index_i;
    end else if (state_q == svna_pkg::T_AWR) begin
      sum_we    = 1'b1;
      sum_wdata = {r[2], r[1], r[0]};
    end
    result_valid_o = res_valid_q;
    normal_x_o     = res_x_q;
    normal_y_o     = res_y_q;
    normal_z_o     = res_z_q;
    status_o       = res_st_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept && (req_type_i == svna_pkg::REQ_LOAD)) begin
      pos_mem[vertex_index_i] <= {pos_z_i, pos_y_i, pos_x_i};
    end
    if (pos_re) begin
      pos_rd_q <= pos_mem[pos_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    if (sum_re) begin
      sum_rd_q <= sum_mem[sum_raddr];
    end
  end

  svna_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_x_i (nin[0]),
    .vec_y_i (nin[1]),
    .vec_z_i (nin[2]),
    .stat_o  (nstat),
    .nrm_x_o (nx),
    .nrm_y_o (ny),
    .nrm_z_o (nz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svna_pkg::T_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      j_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_fire;
      if (state_q == svna_pkg::T_CLEAR) begin
        clr_q <= clr_q + IW'(1);
      end
      if (state_q == svna_pkg::T_EDGE) begin
        step_q <= '0;
      end else if (state_q == svna_pkg::T_CROSS) begin
        step_q <= step_q + 3'd1;
      end
      if (state_q == svna_pkg::T_FNORM) begin
        j_q <= '0;
      end else if (state_q == svna_pkg::T_AWR) begin
        j_q <= j_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      svna_pkg::T_IDLE: begin
        if (accept) begin
          ca_q     <= corner_a_i;
          cb_q     <= corner_b_i;
          cc_q     <= corner_c_i;
          vi_q     <= vertex_index_i;
          res_x_q  <= '0;
          res_y_q  <= '0;
          res_z_q  <= '0;
          res_st_q <= svna_pkg::ST_OK;
        end
      end
      svna_pkg::T_RDB: pa_q <= pos_rd_q;
      svna_pkg::T_RDC: pb_q <= pos_rd_q;
      svna_pkg::T_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EW'(signed'(pb_q[PW*i +: PW])) - EW'(signed'(pa_q[PW*i +: PW]));
          e2_q[i] <= EW'(signed'(pos_rd_q[PW*i +: PW])) - EW'(signed'(pa_q[PW*i +: PW]));
        end
      end
      svna_pkg::T_CROSS: begin
        if (step_q < 3'd6) begin
          prod_q <= op_a * op_b;
        end
        if (step_q != 3'd0) begin
          if (!prev[0]) begin
            hold_q <= prod_q;
          end else begin
            cr_q[prev[2:1]] <= VW'(hold_q) - VW'(prod_q);
          end
        end
      end
      svna_pkg::T_CHECK: begin
        sat_q <= 1'b0;
        if (cr_zero) res_st_q <= svna_pkg::ST_DEGEN;
      end
      svna_pkg::T_AWR: begin
        sat_q <= sat_q | sat_now;
        if (j_q == 2'd2) begin
          res_st_q <= (sat_q | sat_now) ? svna_pkg::ST_SAT : svna_pkg::ST_OK;
        end
      end
      svna_pkg::T_QCHK: begin
        if (sum_zero) res_st_q <= svna_pkg::ST_ZERO;
      end
      svna_pkg::T_QNORM: begin
        if (nstat.done) begin
          res_x_q  <= nx;
          res_y_q  <= ny;
          res_z_q  <= nz;
          res_st_q <= svna_pkg::ST_OK;
        end
      end
      default: begin
        sat_q <= sat_q;
      end
    endcase
  end

endmodule
`default_nettype wire
